// File: design/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// Used by the cell row, the output buffer and the top level; no dependencies.
package mhpq_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int KEY_W        = 32;
	localparam int COUNT_OUT_W  = 8;
	localparam int STATUS_W     = 2;
	localparam int OUT_DATA_W   = 80;

	// Request kinds carried on the slave-side tuser bit
	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_kind_t;

	// Result status codes carried on the master-side tuser bits
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic signed [KEY_W-1:0] value;
	} cell_ctrl_t;

	// One result item
	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] removed_value;
		logic [COUNT_OUT_W-1:0]  count_after;
		logic                    is_empty;
		logic signed [KEY_W-1:0] top_value;
	} result_t;

endpackage

// File: design/mhpq_cell.sv
// One cell of the sorted key row: holds one key and its place in the order.
// Depends on mhpq_pkg for the control struct and key width.
module mhpq_cell
	import mhpq_pkg::*;
#(
	parameter int CNT_W = 8,
	parameter int INDEX = 0
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]        count,
	input  logic                    prev_lt,
	input  logic signed [KEY_W-1:0] prev_key,
	input  logic signed [KEY_W-1:0] next_key,
	output logic signed [KEY_W-1:0] key,
	output logic                    lt
);

	logic signed [KEY_W-1:0] key_q;
	logic                    occupied;

	// An empty cell acts as plus infinity for the insert compare
	always_comb begin
		occupied = CNT_W'(INDEX) < count;
		lt       = !occupied || (ctrl.value < key_q);
	end

	// Insert: shift right from the insert point; delete: shift left
	always_ff @(posedge clk) begin
		if (ctrl.ins && lt) begin
			key_q <= prev_lt ? prev_key : ctrl.value;
		end else if (ctrl.del) begin
			key_q <= next_key;
		end
	end

	assign key = key_q;

endmodule

// File: design/mhpq_out_buf.sv
// Two-entry output buffer (output register plus skid) for result items.
// Depends on mhpq_pkg for the result struct.
module mhpq_out_buf
	import mhpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    push_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || (pop && !skid_valid_q)) begin
			if (push) begin
				out_q <= push_data;
			end
		end else if (pop) begin
			out_q <= skid_q;
		end
		if (out_valid_q && !pop && push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: design/min_heap_priority_queue.sv
// Min-priority queue kept as a row of sorted cells, smallest key in cell 0.
// The result of an accepted request is registered in the output buffer before it reaches the master side.
// Throughput: one request per cycle while the output buffer's skid entry is free; each request is
// one broadcast compare and shift across the cell row.
// Reset (arst_n low) clears the element count and the output buffer; cell keys are
// not cleared, and an empty cell is never read, so no clearing pass runs.
module min_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_W-1:0]      s_tdata,  // [31:0] value
	input  logic                  s_tuser,  // [0] req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] removed_value, [39:32] count_after, [40] is_empty, [72:41] top_value,
	// [79:73] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser   // [1:0] status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]        count_q;
	logic                    accept;
	logic                    full;
	logic                    empty;
	cell_ctrl_t              ctrl;
	logic signed [KEY_W-1:0] key_w [CAPACITY];
	logic                    lt_w  [CAPACITY];
	logic [CNT_W-1:0]        count_next;
	result_t                 res;
	result_t                 out_res;

	assign accept = s_tvalid && s_tready;
	assign full   = count_q == CNT_W'(CAPACITY);
	assign empty  = count_q == '0;

	// Broadcast the request to the row
	always_comb begin
		ctrl.ins   = accept && (s_tuser == REQ_INSERT) && !full;
		ctrl.del   = accept && (s_tuser == REQ_DELETE) && !empty;
		ctrl.value = $signed(s_tdata);
	end

	// Build the cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    prev_lt;
		logic signed [KEY_W-1:0] prev_key;
		logic signed [KEY_W-1:0] next_key;
		if (i == 0) begin : g_first
			assign prev_lt  = 1'b0;
			assign prev_key = ctrl.value;
		end else begin : g_mid
			assign prev_lt  = lt_w[i-1];
			assign prev_key = key_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_key = key_w[i];
		end else begin : g_next
			assign next_key = key_w[i+1];
		end
		mhpq_cell #(
			.CNT_W(CNT_W),
			.INDEX(i)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.count   (count_q),
			.prev_lt (prev_lt),
			.prev_key(prev_key),
			.next_key(next_key),
			.key     (key_w[i]),
			.lt      (lt_w[i])
		);
	end

	// Form the result from the state the request leaves
	always_comb begin
		count_next        = count_q;
		res.status        = ST_OK;
		res.removed_value = '0;
		res.top_value     = key_w[0];
		if (s_tuser == REQ_INSERT) begin
			if (full) begin
				res.status = ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
				if (lt_w[0]) begin
					res.top_value = ctrl.value;
				end
			end
		end else begin
			if (empty) begin
				res.status = ST_EMPTY;
			end else begin
				count_next        = count_q - CNT_W'(1);
				res.removed_value = key_w[0];
				res.top_value     = key_w[1];
			end
		end
		res.count_after = COUNT_OUT_W'(count_next);
		res.is_empty    = count_next == '0;
		if (count_next == '0) begin
			res.top_value = '1;
		end
	end

	// Hold the element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	mhpq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.push_ready(s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {7'd0, out_res.top_value, out_res.is_empty, out_res.count_after,
		out_res.removed_value};

`ifndef SYNTH
	// Count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// An accepted insert into a non-full row grows the count by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == REQ_INSERT) && !full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count");

	// The two lowest occupied cells stay in order
	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (key_w[0] <= key_w[1]))
		else $error("cell row out of order");

	// A stalled result stays valid while a request finds the buffer full
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && !s_tready) |=> m_tvalid)
		else $error("result dropped from output buffer");
`endif

endmodule

// File: tb/mhpq_checker.sv
// Checker for the min-heap priority queue: watches both stream channels,
// predicts every result from its own heap copy and compares field by field.
// Depends on mhpq_pkg for the request kinds, status codes and result layout.
module mhpq_checker
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [KEY_W-1:0]      s_tdata,  // [31:0] value
	input  logic                  s_tuser,  // [0] req_type
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] removed_value, [39:32] count_after, [40] is_empty, [72:41] top_value,
	// [79:73] zero
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [STATUS_W-1:0]   m_tuser,  // [1:0] status
	output int                    mismatch_count,
	output int                    outstanding
);

	// Predicted heap: keys and element count
	logic signed [KEY_W-1:0] heap_keys [CAPACITY];
	int unsigned             heap_size = 0;
	result_t                 predicted_results [$];
	int                      errors_seen = 0;

	function automatic void swap_keys(int unsigned i, int unsigned j);
		logic signed [KEY_W-1:0] tmp;
		tmp          = heap_keys[i];
		heap_keys[i] = heap_keys[j];
		heap_keys[j] = tmp;
	endfunction

	// Apply one request to the predicted heap and build its result
	function automatic result_t heap_apply(req_kind_t kind, logic signed [KEY_W-1:0] key);
		result_t     r;
		int unsigned pos;
		int unsigned parent;
		int unsigned best;
		int unsigned lc;
		int unsigned rc;
		r.status        = ST_OK;
		r.removed_value = '0;
		if (kind == REQ_INSERT) begin
			if (heap_size >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// Place at the end, sift up while strictly smaller than the parent
				pos            = heap_size;
				heap_keys[pos] = key;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (heap_keys[pos] < heap_keys[parent]) begin
						swap_keys(pos, parent);
						pos = parent;
					end else begin
						break;
					end
				end
				heap_size++;
			end
		end else begin
			if (heap_size == 0) begin
				r.status = ST_EMPTY;
			end else begin
				// Take the root, move the last entry up and sift it down
				r.removed_value = heap_keys[0];
				heap_keys[0]    = heap_keys[heap_size - 1];
				heap_size--;
				pos = 0;
				while (pos < heap_size) begin
					best = pos;
					lc   = 2 * pos + 1;
					rc   = 2 * pos + 2;
					if (lc < heap_size && heap_keys[lc] < heap_keys[best])
						best = lc;
					if (rc < heap_size && heap_keys[rc] < heap_keys[best])
						best = rc;
					if (best == pos)
						break;
					swap_keys(pos, best);
					pos = best;
				end
			end
		end
		r.count_after = COUNT_OUT_W'(heap_size);
		r.is_empty    = (heap_size == 0);
		r.top_value   = (heap_size == 0) ? '1 : heap_keys[0];
		return r;
	endfunction

	task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors_seen++;
		end
	endtask

	// Predict on each accepted request, compare on each accepted result
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predicted_results.push_back(heap_apply(req_kind_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result with no request pending, expected none, actual %h/%h",
						$time, m_tuser, m_tdata);
					errors_seen++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", KEY_W'(want.status), KEY_W'(m_tuser));
					check_field("removed_value", want.removed_value, m_tdata[31:0]);
					check_field("count_after", KEY_W'(want.count_after), KEY_W'(m_tdata[39:32]));
					check_field("is_empty", KEY_W'(want.is_empty), KEY_W'(m_tdata[40]));
					check_field("top_value", want.top_value, m_tdata[72:41]);
					check_field("pad", '0, KEY_W'(m_tdata[79:73]));
				end
			end
		end
		mismatch_count <= errors_seen;
		outstanding    <= predicted_results.size();
	end

endmodule

// File: tb/tb_min_heap_priority_queue.sv
// Top of the min-heap priority queue testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on mhpq_pkg, mhpq_checker
// and the block itself.
module tb_min_heap_priority_queue;
	import mhpq_pkg::*;

	localparam int CAP            = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [KEY_W-1:0]      s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	int fail_count;
	int outstanding;

	// Stimulus bookkeeping: occupancy seen by the sender, idle rate, no-idle tail
	int level     = 0;
	int idle_pct  = 0;
	bit quiet     = 1'b0;
	int n_insert  = 0;
	int n_delete  = 0;
	int n_full    = 0;
	int n_empty   = 0;

	min_heap_priority_queue #(.CAPACITY(CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mhpq_checker #(.CAPACITY(CAP)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (fail_count),
		.outstanding    (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Key picker: 0 full range, 1 small range with many repeats, 2 extremes, else any
	function automatic logic [KEY_W-1:0] pick_key(int mode);
		int m;
		m = (mode > 2) ? int'($urandom_range(0, 2)) : mode;
		case (m)
			0: return $urandom;
			1: return KEY_W'(int'($urandom_range(0, 15)) - 8);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Present one request, hold it until accepted, then maybe idle
	task automatic send_req(req_kind_t kind, logic [KEY_W-1:0] key);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == REQ_INSERT) begin
			n_insert++;
			if (level == CAP) n_full++;
			else level++;
		end else begin
			n_delete++;
			if (level == 0) n_empty++;
			else level--;
		end
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic run_mixed(int n, int ins_pct, int mode);
		repeat (n) begin
			if ($urandom_range(0, 99) < ins_pct) send_req(REQ_INSERT, pick_key(mode));
			else send_req(REQ_DELETE, $urandom);
		end
	endtask

	// Fill to capacity with occasional deletes, then push against the full queue
	task automatic run_fill(int mode);
		while (level < CAP) begin
			if ($urandom_range(0, 9) != 0) send_req(REQ_INSERT, pick_key(mode));
			else send_req(REQ_DELETE, $urandom);
		end
		repeat (3) send_req(REQ_INSERT, pick_key(mode));
	endtask

	// Drain to empty with occasional inserts, then delete from the empty queue
	task automatic run_drain(int mode);
		while (level > 0) begin
			if ($urandom_range(0, 9) != 0) send_req(REQ_DELETE, $urandom);
			else send_req(REQ_INSERT, pick_key(mode));
		end
		repeat (3) send_req(REQ_DELETE, $urandom);
	endtask

	// Result back-pressure: ready stretches broken by stall bursts
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				if (!quiet && $urandom_range(0, 3) != 0) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 19)) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog expired at %0t with %0d results outstanding", $time, outstanding);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty delete, key extremes, repeats, drain past empty
		idle_pct = 30;
		send_req(REQ_DELETE, 32'hDEAD_BEEF);
		send_req(REQ_INSERT, 32'h7FFF_FFFF);
		send_req(REQ_INSERT, 32'h8000_0000);
		send_req(REQ_INSERT, 32'h0000_0000);
		send_req(REQ_INSERT, 32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'd5);
		send_req(REQ_INSERT, 32'd5);
		send_req(REQ_INSERT, 32'hFFFF_FFFF);
		repeat (3) send_req(REQ_DELETE, 32'h5555_5555);
		repeat (3) send_req(REQ_INSERT, 32'd7);
		repeat (8) send_req(REQ_DELETE, 32'hAAAA_AAAA);

		// Random phases: mixed traffic, fill and drain cycles at several idle rates
		idle_pct = 20;
		run_mixed(40, 55, 0);
		idle_pct = 10;
		run_fill(1);
		idle_pct = 30;
		run_drain(1);
		idle_pct = 0;
		run_fill(0);
		idle_pct = 20;
		run_mixed(30, 50, 3);
		idle_pct = 15;
		run_drain(3);

		// Tail without any idling on either side
		quiet = 1'b1;
		run_mixed(40, 60, 3);
		run_drain(0);
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("run covered %0d inserts (%0d against a full queue) and %0d deletes",
			n_insert, n_full, n_delete);
		$display("deletes against an empty queue: %0d, mismatches: %0d", n_empty, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
